/* rtl/mcpg_pkg.sv */
// Shared types, constants and offset tables for the midpoint circle point generator.
`default_nettype none

package mcpg_pkg;

    localparam int COORD_W = 10;
    localparam int RAD_W   = COORD_W - 1;
    localparam int OUT_W   = COORD_W + 2;
    localparam int STEP_W  = COORD_W + 2;
    localparam int DEC_W   = COORD_W + 4;
    localparam int OCT_W   = 3;

    localparam logic [OCT_W-1:0] OCT_LAST = OCT_W'(7);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_CONT  = 1'b1;

    typedef enum logic [1:0] {
        SEL_PX = 2'd0,
        SEL_NX = 2'd1,
        SEL_PY = 2'd2,
        SEL_NY = 2'd3
    } sel_t;

    // One step of a circle, as handed from the front to the back.
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               done;
    } step_t;

    function automatic sel_t dx_sel(input logic [OCT_W-1:0] k);
        sel_t s;
        unique case (k)
            3'd0:    s = SEL_PX;
            3'd1:    s = SEL_NY;
            3'd2:    s = SEL_PY;
            3'd3:    s = SEL_NY;
            3'd4:    s = SEL_PY;
            3'd5:    s = SEL_NX;
            3'd6:    s = SEL_PX;
            default: s = SEL_NX;
        endcase
        return s;
    endfunction

    function automatic sel_t dy_sel(input logic [OCT_W-1:0] k);
        sel_t s;
        unique case (k)
            3'd0:    s = SEL_PY;
            3'd1:    s = SEL_NX;
            3'd2:    s = SEL_NX;
            3'd3:    s = SEL_PX;
            3'd4:    s = SEL_PX;
            3'd5:    s = SEL_NY;
            3'd6:    s = SEL_NY;
            default: s = SEL_PY;
        endcase
        return s;
    endfunction

    function automatic logic signed [OUT_W-1:0] pick(
        input sel_t               s,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic signed [OUT_W-1:0] xe;
        logic signed [OUT_W-1:0] ye;
        logic signed [OUT_W-1:0] r;
        xe = OUT_W'(x);
        ye = OUT_W'(y);
        unique case (s)
            SEL_PX:  r = xe;
            SEL_NX:  r = -xe;
            SEL_PY:  r = ye;
            default: r = -ye;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/mcpg_front.sv */
// Front end: accepts items, tracks the circle state and queues one step per emitting item.
`default_nettype none

module mcpg_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [mcpg_pkg::COORD_W-1:0]    centre_x,
    input  wire logic [mcpg_pkg::COORD_W-1:0]    centre_y,
    input  wire logic [mcpg_pkg::RAD_W-1:0]      radius,
    input  wire logic                            q_full,
    output logic                                 push,
    output mcpg_pkg::step_t                      push_data
);

    logic                                active_reg, active_next;
    logic [mcpg_pkg::COORD_W-1:0]        cur_x_reg, cur_x_next;
    logic [mcpg_pkg::COORD_W-1:0]        cur_y_reg, cur_y_next;
    logic signed [mcpg_pkg::DEC_W-1:0]   decision_reg, decision_next;
    logic [mcpg_pkg::COORD_W-1:0]        held_cx_reg, held_cx_next;
    logic [mcpg_pkg::COORD_W-1:0]        held_cy_reg, held_cy_next;

    logic                                fire;
    logic                                start;
    logic [mcpg_pkg::COORD_W-1:0]        x_sel, y_sel, cx_sel, cy_sel;
    logic signed [mcpg_pkg::DEC_W-1:0]   d_sel, d_init, x_d, y_d, delta;
    logic                                d_le;
    logic signed [mcpg_pkg::STEP_W-1:0]  x_step, y_step;
    logic                                done;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign start    = (kind == mcpg_pkg::KIND_START);

    always_comb
    begin
        d_init = mcpg_pkg::DEC_W'(3) - (mcpg_pkg::DEC_W'(radius) <<< 1);
        x_sel  = start ? '0 : cur_x_reg;
        y_sel  = start ? mcpg_pkg::COORD_W'(radius) : cur_y_reg;
        cx_sel = start ? centre_x : held_cx_reg;
        cy_sel = start ? centre_y : held_cy_reg;
        d_sel  = start ? d_init : decision_reg;

        d_le   = d_sel[mcpg_pkg::DEC_W-1] || (d_sel == '0);
        x_d    = mcpg_pkg::DEC_W'(x_sel);
        y_d    = mcpg_pkg::DEC_W'(y_sel);
        delta  = d_le ? ((x_d <<< 2) + mcpg_pkg::DEC_W'(6))
                      : (((x_d - y_d) <<< 2) + mcpg_pkg::DEC_W'(10));

        x_step = mcpg_pkg::STEP_W'(x_sel) + mcpg_pkg::STEP_W'(1);
        y_step = d_le ? mcpg_pkg::STEP_W'(y_sel)
                      : mcpg_pkg::STEP_W'(y_sel) - mcpg_pkg::STEP_W'(1);
        done   = (x_step > y_step);

        push           = fire && (start || active_reg);
        push_data.cx   = cx_sel;
        push_data.cy   = cy_sel;
        push_data.x    = x_sel;
        push_data.y    = y_sel;
        push_data.done = done;

        active_next   = active_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        decision_next = decision_reg;
        held_cx_next  = held_cx_reg;
        held_cy_next  = held_cy_reg;
        // Drop a continue with no circle in progress: state stays as is.
        if (push)
        begin
            active_next   = !done;
            cur_x_next    = x_step[mcpg_pkg::COORD_W-1:0];
            cur_y_next    = y_step[mcpg_pkg::STEP_W-1] ? '0 : y_step[mcpg_pkg::COORD_W-1:0];
            decision_next = d_sel + delta;
            held_cx_next  = cx_sel;
            held_cy_next  = cy_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            decision_reg <= '0;
            held_cx_reg  <= '0;
            held_cy_reg  <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            decision_reg <= decision_next;
            held_cx_reg  <= held_cx_next;
            held_cy_reg  <= held_cy_next;
        end
    end

    a_idle_continue_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && kind == mcpg_pkg::KIND_CONT && !active_reg) |-> !push)
        else $error("continue item queued with no circle in progress");

endmodule

`default_nettype wire

/* rtl/mcpg_queue.sv */
// Short step queue between the front end and the point emitter.
`default_nettype none

module mcpg_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mcpg_pkg::step_t  push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output mcpg_pkg::step_t       head_data
);

    mcpg_pkg::step_t                  mem [mcpg_pkg::QDEPTH];
    logic [mcpg_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [mcpg_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [mcpg_pkg::QCNT_W-1:0]      count_reg, count_next;

    function automatic logic [mcpg_pkg::QPTR_W-1:0] bump(
        input logic [mcpg_pkg::QPTR_W-1:0] p
    );
        logic [mcpg_pkg::QPTR_W-1:0] r;
        if (p == mcpg_pkg::QPTR_W'(mcpg_pkg::QDEPTH - 1))
            r = '0;
        else
            r = p + mcpg_pkg::QPTR_W'(1);
        return r;
    endfunction

    assign full       = (count_reg == mcpg_pkg::QCNT_W'(mcpg_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + mcpg_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - mcpg_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("step queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop)
        else $error("step queue read while empty");

endmodule

`default_nettype wire

/* rtl/mcpg_back.sv */
// Point emitter: walks the eight symmetric points of each queued step into the output register.
`default_nettype none

module mcpg_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  head_valid,
    input  wire mcpg_pkg::step_t                       head_data,
    output logic                                       pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [mcpg_pkg::OUT_W-1:0]          point_x,
    output logic signed [mcpg_pkg::OUT_W-1:0]          point_y,
    output logic [mcpg_pkg::OCT_W-1:0]                 octant,
    output logic                                       step_last,
    output logic                                       circle_done
);

    logic                                   out_valid_reg, out_valid_next;
    logic [mcpg_pkg::OCT_W-1:0]             cnt_reg, cnt_next;
    logic signed [mcpg_pkg::OUT_W-1:0]      px_reg, px_next;
    logic signed [mcpg_pkg::OUT_W-1:0]      py_reg, py_next;
    logic [mcpg_pkg::OCT_W-1:0]             oct_reg;
    logic                                   last_reg;
    logic                                   done_reg;
    logic                                   load;

    always_comb
    begin
        load = head_valid && (!out_valid_reg || out_ready);
        pop  = load && (cnt_reg == mcpg_pkg::OCT_LAST);

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;

        // Advance through the octants; wrap back to zero on the last point.
        cnt_next = load ? cnt_reg + mcpg_pkg::OCT_W'(1) : cnt_reg;

        px_next = mcpg_pkg::OUT_W'(head_data.cx)
                + mcpg_pkg::pick(mcpg_pkg::dx_sel(cnt_reg), head_data.x, head_data.y);
        py_next = mcpg_pkg::OUT_W'(head_data.cy)
                + mcpg_pkg::pick(mcpg_pkg::dy_sel(cnt_reg), head_data.x, head_data.y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            oct_reg  <= cnt_reg;
            last_reg <= (cnt_reg == mcpg_pkg::OCT_LAST);
            done_reg <= head_data.done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign octant      = oct_reg;
    assign step_last   = last_reg;
    assign circle_done = done_reg;

    a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (cnt_reg == '0) && out_valid_reg)
        else $error("octant count did not restart after a step was emitted");

endmodule

`default_nettype wire

/* rtl/midpoint_circle_point_generator_unit.sv */
// Midpoint circle point generator: front end, step queue and point emitter.
// A step's first point passes the step queue and then the output register after acceptance.
// Each emitting item gives eight points, one point per cycle out of the single output
// register while out_ready allows; the front end takes an item each cycle while the 2-entry
// step queue has room; items that emit nothing (a continue with no circle) queue no step.
// Reset (rst_n low, asynchronous) clears the circle state, empties the queue and the output.
`default_nettype none

module midpoint_circle_point_generator_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  kind,
    input  wire logic [mcpg_pkg::COORD_W-1:0]          centre_x,
    input  wire logic [mcpg_pkg::COORD_W-1:0]          centre_y,
    input  wire logic [mcpg_pkg::RAD_W-1:0]            radius,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [mcpg_pkg::OUT_W-1:0]          point_x,
    output logic signed [mcpg_pkg::OUT_W-1:0]          point_y,
    output logic [mcpg_pkg::OCT_W-1:0]                 octant,
    output logic                                       step_last,
    output logic                                       circle_done
);

    logic             q_full;
    logic             push;
    mcpg_pkg::step_t  push_data;
    logic             pop;
    logic             head_valid;
    mcpg_pkg::step_t  head_data;

    mcpg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .centre_x  (centre_x),
        .centre_y  (centre_y),
        .radius    (radius),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    mcpg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    mcpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .octant      (octant),
        .step_last   (step_last),
        .circle_done (circle_done)
    );

endmodule

`default_nettype wire
